### sv/price_time_order_matcher_defines.svh
// assertion macros for the order matcher
`ifndef PRICE_TIME_ORDER_MATCHER_DEFINES_SVH
`define PRICE_TIME_ORDER_MATCHER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PTOM_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define PTOM_ASSERT_R(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define PTOM_ASSERT(label, clk, rst, prop)
`define PTOM_ASSERT_R(label, clk, prop)
`endif
`endif

### sv/ptom_pkg.sv
// ----------------------------------------------------------------------------
// ptom_pkg
// types and codes shared by the order matcher modules
// ----------------------------------------------------------------------------
`default_nettype none
package ptom_pkg;
  localparam logic [1:0] FUNC_ADD_BUY  = 2'd0;
  localparam logic [1:0] FUNC_ADD_SELL = 2'd1;
  localparam logic [1:0] FUNC_EXECUTE  = 2'd2;

  localparam logic [1:0] KIND_TRADE    = 2'd0;
  localparam logic [1:0] KIND_ACCEPTED = 2'd1;
  localparam logic [1:0] KIND_REJECTED = 2'd2;
  localparam logic [1:0] KIND_NO_TRADE = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] price;
    logic [31:0] order_id;
    logic [31:0] quantity;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] buy_order_id;
    logic [31:0] sell_order_id;
    logic [31:0] bid_price;
    logic [31:0] ask_price;
    logic [31:0] traded_quantity;
    logic        last;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_MATCH,
    ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic insert;
    logic trade;
    logic emit_add;
    logic emit_none;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_buy;
    logic is_sell;
    logic is_exec;
    logic side_full;
    logic can_match;
    logic more_after;
  } stat_t;
endpackage
`default_nettype wire

### sv/ptom_book.sv
// ----------------------------------------------------------------------------
// ptom_book
// datapath: two sorted shift-chain books, request latch and result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "price_time_order_matcher_defines.svh"
module ptom_book #(
  parameter int BOOK_DEPTH = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire ptom_pkg::req_t  req,
  input  wire ptom_pkg::cmd_t  cmd,
  output ptom_pkg::stat_t      stat,
  output ptom_pkg::rsp_t       rsp
);
  localparam int CW = $clog2(BOOK_DEPTH + 1);
  localparam int IW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;

  logic [31:0] bp [BOOK_DEPTH];
  logic [31:0] bi [BOOK_DEPTH];
  logic [31:0] bq [BOOK_DEPTH];
  logic [31:0] ap [BOOK_DEPTH];
  logic [31:0] ai [BOOK_DEPTH];
  logic [31:0] aq [BOOK_DEPTH];
  logic [CW-1:0] bid_count;
  logic [CW-1:0] ask_count;
  ptom_pkg::req_t cur;

  logic [IW-1:0] btop, atop;
  logic [31:0] tbp, tbq, tbi, tap, taq, tai, tq, rbq, raq;
  logic bid_gone, ask_gone;
  logic [CW-1:0] bcn, acn;
  logic [BOOK_DEPTH-1:0] bworse, aworse;

  assign btop = IW'(bid_count - CW'(1));
  assign atop = IW'(ask_count - CW'(1));
  assign tbp = bp[btop];
  assign tbq = bq[btop];
  assign tbi = bi[btop];
  assign tap = ap[atop];
  assign taq = aq[atop];
  assign tai = ai[atop];
  assign tq  = (tbq < taq) ? tbq : taq;
  assign rbq = tbq - tq;
  assign raq = taq - tq;
  assign bid_gone = (rbq == 32'd0);
  assign ask_gone = (raq == 32'd0);
  assign bcn = bid_gone ? bid_count - CW'(1) : bid_count;
  assign acn = ask_gone ? ask_count - CW'(1) : ask_count;

  // an entry is "worse" than the new order, so the new order goes above it
  always_comb begin
    for (int k = 0; k < BOOK_DEPTH; k++) begin
      bworse[k] = (CW'(k) < bid_count) && (bp[k] < cur.price);
      aworse[k] = (CW'(k) < ask_count) && (ap[k] > cur.price);
    end
  end

  always_comb begin
    stat.is_buy     = (cur.func == ptom_pkg::FUNC_ADD_BUY);
    stat.is_sell    = (cur.func == ptom_pkg::FUNC_ADD_SELL);
    stat.is_exec    = (cur.func == ptom_pkg::FUNC_EXECUTE);
    stat.side_full  = stat.is_buy ? (bid_count == CW'(BOOK_DEPTH))
                                  : (ask_count == CW'(BOOK_DEPTH));
    stat.can_match  = (bid_count != '0) && (ask_count != '0) && (tap <= tbp);
    // does the book still cross after this trade
    stat.more_after = (bcn != '0) && (acn != '0) &&
                      (ap[IW'(acn - CW'(1))] <= bp[IW'(bcn - CW'(1))]);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= req;
    end
  end

  // shift chains: worse entries stay, the rest move up one slot
  always_ff @(posedge clk) begin
    if (cmd.insert && stat.is_buy && !stat.side_full) begin
      for (int k = 0; k < BOOK_DEPTH; k++) begin
        if (!bworse[k] && CW'(k) <= bid_count) begin
          if (k == 0 || bworse[k-1 < 0 ? 0 : k-1]) begin
            bp[k] <= cur.price;
            bi[k] <= cur.order_id;
            bq[k] <= cur.quantity;
          end else begin
            bp[k] <= bp[k-1 < 0 ? 0 : k-1];
            bi[k] <= bi[k-1 < 0 ? 0 : k-1];
            bq[k] <= bq[k-1 < 0 ? 0 : k-1];
          end
        end
      end
    end
    if (cmd.insert && stat.is_sell && !stat.side_full) begin
      for (int k = 0; k < BOOK_DEPTH; k++) begin
        if (!aworse[k] && CW'(k) <= ask_count) begin
          if (k == 0 || aworse[k-1 < 0 ? 0 : k-1]) begin
            ap[k] <= cur.price;
            ai[k] <= cur.order_id;
            aq[k] <= cur.quantity;
          end else begin
            ap[k] <= ap[k-1 < 0 ? 0 : k-1];
            ai[k] <= ai[k-1 < 0 ? 0 : k-1];
            aq[k] <= aq[k-1 < 0 ? 0 : k-1];
          end
        end
      end
    end
    if (cmd.trade) begin
      bq[btop] <= rbq;
      aq[atop] <= raq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bid_count <= '0;
      ask_count <= '0;
    end else if (cmd.insert && !stat.side_full) begin
      if (stat.is_buy) begin
        bid_count <= bid_count + CW'(1);
      end
      if (stat.is_sell) begin
        ask_count <= ask_count + CW'(1);
      end
    end else if (cmd.trade) begin
      bid_count <= bcn;
      ask_count <= acn;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.trade) begin
      rsp <= '{ptom_pkg::KIND_TRADE, tbi, tai, tbp, tap, tq, !stat.more_after};
    end else if (cmd.emit_add) begin
      rsp <= '{stat.side_full ? ptom_pkg::KIND_REJECTED : ptom_pkg::KIND_ACCEPTED,
               32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1};
    end else if (cmd.emit_none) begin
      rsp <= '{ptom_pkg::KIND_NO_TRADE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1};
    end
  end

  `PTOM_ASSERT(a_bid_bound, clk, rst, bid_count <= CW'(BOOK_DEPTH))
  `PTOM_ASSERT(a_ask_bound, clk, rst, ask_count <= CW'(BOOK_DEPTH))
  `PTOM_ASSERT(a_one_cmd, clk, rst, $onehot0({cmd.insert, cmd.trade, cmd.emit_none}))
endmodule
`default_nettype wire

### sv/ptom_ctrl.sv
// ----------------------------------------------------------------------------
// ptom_ctrl
// controller: sequences insert, trade loop and result handshake
// ----------------------------------------------------------------------------
`default_nettype none
`include "price_time_order_matcher_defines.svh"
module ptom_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire logic            rsp_last,
  input  wire ptom_pkg::stat_t stat,
  output ptom_pkg::cmd_t       cmd
);
  ptom_pkg::state_t state, state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      ptom_pkg::ST_IDLE:   if (in_valid) state_next = ptom_pkg::ST_INSERT;
      ptom_pkg::ST_INSERT: begin
        if (stat.is_buy || stat.is_sell) state_next = ptom_pkg::ST_OUT;
        else if (stat.is_exec) state_next = ptom_pkg::ST_MATCH;
        else state_next = ptom_pkg::ST_IDLE;
      end
      ptom_pkg::ST_MATCH:  state_next = ptom_pkg::ST_OUT;
      ptom_pkg::ST_OUT: begin
        if (out_ready) begin
          state_next = rsp_last ? ptom_pkg::ST_IDLE : ptom_pkg::ST_MATCH;
        end
      end
      default: state_next = ptom_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ptom_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ptom_pkg::ST_INSERT: begin
        cmd.insert   = stat.is_buy || stat.is_sell;
        cmd.emit_add = stat.is_buy || stat.is_sell;
      end
      ptom_pkg::ST_MATCH: begin
        cmd.trade     = stat.can_match;
        cmd.emit_none = !stat.can_match;
      end
      ptom_pkg::ST_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ptom_pkg::ST_IDLE;
    else state <= state_next;
  end

  `PTOM_ASSERT(a_excl, clk, rst, !(in_ready && out_valid))
  `PTOM_ASSERT(a_load_idle, clk, rst, cmd.load |=> state == ptom_pkg::ST_INSERT)
  `PTOM_ASSERT(a_match_out, clk, rst, state == ptom_pkg::ST_MATCH |=> out_valid)
endmodule
`default_nettype wire

### sv/price_time_order_matcher.sv
// ----------------------------------------------------------------------------
// price_time_order_matcher
// price-time priority limit order book with matching
// ----------------------------------------------------------------------------
// One request at a time. An add passes through accept, shift-chain insert and
// result; an execute passes through accept and decode, then a match state and
// a result state for each trade (or for the single no-trade result), each
// trade computed from the tops of both chains and held in the result register
// until taken. No clearing pass: only entries below the counts are read.
`default_nettype none
module price_time_order_matcher #(
  parameter int BOOK_DEPTH = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire ptom_pkg::req_t in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output ptom_pkg::rsp_t      out_data
);
  ptom_pkg::cmd_t  cmd;
  ptom_pkg::stat_t stat;

  ptom_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .rsp_last(out_data.last),
    .stat(stat), .cmd(cmd)
  );

  ptom_book #(.BOOK_DEPTH(BOOK_DEPTH)) u_book (
    .clk(clk), .rst(rst), .req(in_data), .cmd(cmd), .stat(stat), .rsp(out_data)
  );
endmodule
`default_nettype wire

### tb/price_time_order_matcher_tb.sv
// ----------------------------------------------------------------------------
// price_time_order_matcher_tb
// randomized self-checking bench for the order matcher
// ----------------------------------------------------------------------------
// Adds and executes are driven through the request channel. A local model of
// both books predicts every response, and the monitor compares each response
// with the oldest prediction. Idle and stall rates change from phase to phase.
`timescale 1ns / 100ps
`default_nettype none
module price_time_order_matcher_tb;
  localparam int DEPTH = 16;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  ptom_pkg::req_t in_data;
  logic out_valid;
  logic out_ready;
  ptom_pkg::rsp_t out_data;

  price_time_order_matcher #(.BOOK_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  ptom_pkg::req_t pending_reqs[$];
  ptom_pkg::rsp_t expected_rsps[$];
  int   errors = 0;
  int   send_idle_pct;
  int   recv_stall_pct;
  bit   hold_send;

  // model copy of both books, index count-1 is the best order
  logic [31:0] bid_px[DEPTH], bid_id[DEPTH], bid_qty[DEPTH];
  logic [31:0] ask_px[DEPTH], ask_id[DEPTH], ask_qty[DEPTH];
  int bid_n = 0;
  int ask_n = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic ptom_pkg::rsp_t make_rsp(logic [1:0] kind, logic [31:0] bid,
                                              logic [31:0] sid, logic [31:0] bp,
                                              logic [31:0] sp, logic [31:0] q,
                                              logic last);
    ptom_pkg::rsp_t r;
    r.kind = kind; r.buy_order_id = bid; r.sell_order_id = sid;
    r.bid_price = bp; r.ask_price = sp; r.traded_quantity = q; r.last = last;
    return r;
  endfunction

  task automatic add_req(input ptom_pkg::req_t r);
    pending_reqs = {pending_reqs, r};
  endtask

  task automatic expect_rsp(input ptom_pkg::rsp_t r);
    expected_rsps = {expected_rsps, r};
  endtask

  task automatic predict_book(input ptom_pkg::req_t rq);
    int pos;
    logic [31:0] q;
    int ntr;
    if (rq.func == ptom_pkg::FUNC_ADD_BUY || rq.func == ptom_pkg::FUNC_ADD_SELL) begin
      if (rq.func == ptom_pkg::FUNC_ADD_BUY && bid_n < DEPTH) begin
        pos = 0;
        while (pos < bid_n && bid_px[pos] < rq.price) pos++;
        for (int i = bid_n; i > pos; i--) begin
          bid_px[i] = bid_px[i-1]; bid_id[i] = bid_id[i-1]; bid_qty[i] = bid_qty[i-1];
        end
        bid_px[pos] = rq.price; bid_id[pos] = rq.order_id; bid_qty[pos] = rq.quantity;
        bid_n++;
        expect_rsp(make_rsp(ptom_pkg::KIND_ACCEPTED, 0, 0, 0, 0, 0, 1'b1));
      end else if (rq.func == ptom_pkg::FUNC_ADD_SELL && ask_n < DEPTH) begin
        pos = 0;
        while (pos < ask_n && ask_px[pos] > rq.price) pos++;
        for (int i = ask_n; i > pos; i--) begin
          ask_px[i] = ask_px[i-1]; ask_id[i] = ask_id[i-1]; ask_qty[i] = ask_qty[i-1];
        end
        ask_px[pos] = rq.price; ask_id[pos] = rq.order_id; ask_qty[pos] = rq.quantity;
        ask_n++;
        expect_rsp(make_rsp(ptom_pkg::KIND_ACCEPTED, 0, 0, 0, 0, 0, 1'b1));
      end else begin
        expect_rsp(make_rsp(ptom_pkg::KIND_REJECTED, 0, 0, 0, 0, 0, 1'b1));
      end
    end else if (rq.func == ptom_pkg::FUNC_EXECUTE) begin
      ntr = 0;
      while (bid_n > 0 && ask_n > 0 && ask_px[ask_n-1] <= bid_px[bid_n-1]) begin
        q = (bid_qty[bid_n-1] < ask_qty[ask_n-1]) ? bid_qty[bid_n-1] : ask_qty[ask_n-1];
        expect_rsp(make_rsp(ptom_pkg::KIND_TRADE, bid_id[bid_n-1], ask_id[ask_n-1],
                            bid_px[bid_n-1], ask_px[ask_n-1], q, 1'b0));
        bid_qty[bid_n-1] -= q;
        ask_qty[ask_n-1] -= q;
        ntr++;
        if (bid_qty[bid_n-1] == 0) bid_n--;
        if (ask_qty[ask_n-1] == 0) ask_n--;
      end
      if (ntr == 0)
        expect_rsp(make_rsp(ptom_pkg::KIND_NO_TRADE, 0, 0, 0, 0, 0, 1'b1));
      else
        expected_rsps[$].last = 1'b1;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // driver: predictions are made at acceptance
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_book(in_data);
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() > 0 && !hold_send &&
            $urandom_range(99) >= send_idle_pct) begin
          in_data  <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    ptom_pkg::rsp_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("unexpected response", 32'(out_data.kind), 32'd0);
        end else begin
          want = expected_rsps.pop_front();
          if (out_data.kind !== want.kind)
            report_mismatch("kind", 32'(out_data.kind), 32'(want.kind));
          if (out_data.buy_order_id !== want.buy_order_id)
            report_mismatch("buy_order_id", out_data.buy_order_id, want.buy_order_id);
          if (out_data.sell_order_id !== want.sell_order_id)
            report_mismatch("sell_order_id", out_data.sell_order_id, want.sell_order_id);
          if (out_data.bid_price !== want.bid_price)
            report_mismatch("bid_price", out_data.bid_price, want.bid_price);
          if (out_data.ask_price !== want.ask_price)
            report_mismatch("ask_price", out_data.ask_price, want.ask_price);
          if (out_data.traded_quantity !== want.traded_quantity)
            report_mismatch("traded_quantity", out_data.traded_quantity,
                            want.traded_quantity);
          if (out_data.last !== want.last)
            report_mismatch("last", 32'(out_data.last), 32'(want.last));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic ptom_pkg::req_t mk_req(logic [1:0] f, logic [31:0] p,
                                            logic [31:0] id, logic [31:0] q);
    ptom_pkg::req_t r;
    r.func = f; r.price = p; r.order_id = id; r.quantity = q;
    return r;
  endfunction

  // mostly clustered prices so that books cross; sometimes full-range values
  function automatic ptom_pkg::req_t random_req(int base);
    ptom_pkg::req_t r;
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) r.func = ptom_pkg::FUNC_ADD_BUY;
    else if (pick < 80) r.func = ptom_pkg::FUNC_ADD_SELL;
    else if (pick < 97) r.func = ptom_pkg::FUNC_EXECUTE;
    else r.func = FUNC_UNUSED;
    r.order_id = $urandom();
    if ($urandom_range(9) == 0) begin
      r.price = $urandom();
      r.quantity = $urandom();
    end else begin
      r.price = base + $urandom_range(20);
      r.quantity = $urandom_range(8);
    end
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_send = 1'b0;
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: empty execute, extremes, equal price time priority, zero qty
    add_req(mk_req(ptom_pkg::FUNC_EXECUTE, 0, 0, 0));
    add_req(mk_req(ptom_pkg::FUNC_ADD_BUY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    add_req(mk_req(ptom_pkg::FUNC_ADD_SELL, 0, 0, 0));
    add_req(mk_req(ptom_pkg::FUNC_ADD_SELL, 0, 32'h1, 32'hFFFF_FFFF));
    add_req(mk_req(FUNC_UNUSED, 5, 5, 5));
    add_req(mk_req(ptom_pkg::FUNC_EXECUTE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    add_req(mk_req(ptom_pkg::FUNC_ADD_BUY, 100, 10, 3));
    add_req(mk_req(ptom_pkg::FUNC_ADD_BUY, 100, 11, 4));
    add_req(mk_req(ptom_pkg::FUNC_ADD_SELL, 101, 20, 2));
    add_req(mk_req(ptom_pkg::FUNC_EXECUTE, 0, 0, 0));
    add_req(mk_req(ptom_pkg::FUNC_ADD_SELL, 99, 21, 5));
    add_req(mk_req(ptom_pkg::FUNC_ADD_SELL, 100, 22, 9));
    add_req(mk_req(ptom_pkg::FUNC_EXECUTE, 0, 0, 0));
    // fill the buy side past full, then execute against the resting sells
    for (int i = 0; i < 17; i++)
      add_req(mk_req(ptom_pkg::FUNC_ADD_BUY, 500 + i, 100 + i, 1 + i % 3));
    add_req(mk_req(ptom_pkg::FUNC_EXECUTE, 0, 0, 0));
    wait_drained();

    // full books, many-trade execute
    for (int i = 0; i < 18; i++)
      add_req(mk_req(ptom_pkg::FUNC_ADD_SELL, 10 + i % 4, 300 + i, 1 + i % 2));
    for (int i = 0; i < 17; i++)
      add_req(mk_req(ptom_pkg::FUNC_ADD_BUY, 40 - i % 3, 400 + i, 2));
    add_req(mk_req(ptom_pkg::FUNC_EXECUTE, 0, 0, 0));
    add_req(mk_req(ptom_pkg::FUNC_EXECUTE, 0, 0, 0));
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      for (int i = 0; i < 48; i++)
        add_req(random_req(1000 * ph));
      // pause the sender once until the response stream is empty
      if (ph == 2) begin
        while (pending_reqs.size() > 24) @(posedge clk);
        hold_send = 1'b1;
        while (in_valid || expected_rsps.size() > 0) @(posedge clk);
        repeat (3) @(posedge clk);
        hold_send = 1'b0;
      end
      add_req(mk_req(ptom_pkg::FUNC_EXECUTE, 0, 0, 0));
      wait_drained();
    end

    if (errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #(20ns * 200000);
    $display("FAILED: results differ");
    $finish;
  end
endmodule
`default_nettype wire

### files.f
+incdir+sv
sv/ptom_pkg.sv
sv/ptom_book.sv
sv/ptom_ctrl.sv
sv/price_time_order_matcher.sv
tb/price_time_order_matcher_tb.sv
